// ----- rtl/core/pipc_pkg.sv -----
// pipc_pkg: shared types and constants for the point-in-polygon crossing block
// used by pipc_front, pipc_back and the top level; depends on nothing

package pipc_pkg;

    localparam int FieldBits = 32;

    localparam logic OpStart  = 1'b0;
    localparam logic OpVertex = 1'b1;

    localparam logic [1:0] TallyZero = 2'd0;
    localparam logic [1:0] TallyOne  = 2'd1;
    localparam logic [1:0] TallyFull = 2'd3;

    // control half of one edge job, coordinates travel beside it
    typedef struct packed {
        logic lane0_en;
        logic lane1_en;
        logic fresh;
        logic emit;
        logic too_few;
        logic mode;
    } job_ctl_t;

endpackage

// ----- rtl/core/pipc_in_if.sv -----
// pipc_in_if: input channel of the crossing block, one point or vertex per beat
// depends on nothing

interface pipc_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               last_vertex;

    modport source (output valid, output op, output coord_x, output coord_y,
                    output last_vertex, input ready);
    modport sink   (input valid, input op, input coord_x, input coord_y,
                    input last_vertex, output ready);
endinterface

// ----- rtl/core/pipc_out_if.sv -----
// pipc_out_if: result channel of the crossing block, one polygon verdict per beat
// depends on nothing

interface pipc_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic too_few_vertices;

    modport source (output valid, output inside_res, output too_few_vertices,
                    input ready);
    modport sink   (input valid, input inside_res, input too_few_vertices,
                    output ready);
endinterface

// ----- rtl/core/pipc_fifo.sv -----
// pipc_fifo: small register queue of edge jobs between front and back
// depends on nothing

module pipc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);
    localparam int IdxBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [IdxBits-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IdxBits-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntBits-1:0] count_reg, count_next;

    function automatic logic [IdxBits-1:0] bump(input logic [IdxBits-1:0] p);
        logic [IdxBits-1:0] r;
        if (p == IdxBits'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign push_ready = (count_reg != CntBits'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/pipc_front.sv -----
// pipc_front: takes input beats, tracks query point and vertex history,
// and issues edge jobs into the queue; depends on pipc_pkg and pipc_in_if

module pipc_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pipc_in_if.sink                         vtx,
    input  logic                            cfg_we,
    input  logic                            cfg_data,
    input  logic                            job_room,
    output logic                            job_push,
    output logic [8*COORD_BITS+5:0]         job_data
);
    import pipc_pkg::*;

    localparam int CB = COORD_BITS;

    logic signed [CB-1:0] cx, cy, fx;
    logic signed [CB-1:0] fy;
    logic signed [CB-1:0] qx_reg, qy_reg, qx_next, qy_next;
    logic signed [CB-1:0] fx_reg, fy_reg, fx_next, fy_next;
    logic signed [CB-1:0] px_reg, py_reg, px_next, py_next;
    logic [1:0]           tally_reg, tally_next, tally_inc;
    logic                 mode_reg;
    logic                 beat;
    job_ctl_t             ctl;

    if (CB <= FieldBits)
    begin : g_narrow
        assign cx = vtx.coord_x[CB-1:0];
        assign cy = vtx.coord_y[CB-1:0];
    end
    else
    begin : g_wide
        assign cx = {{(CB - FieldBits){vtx.coord_x[FieldBits-1]}}, vtx.coord_x};
        assign cy = {{(CB - FieldBits){vtx.coord_y[FieldBits-1]}}, vtx.coord_y};
    end

    assign vtx.ready = job_room;
    assign beat      = vtx.valid && vtx.ready;

    // first vertex closes on itself when it is also the last
    assign fx = (tally_reg == TallyZero) ? cx : fx_reg;
    assign fy = (tally_reg == TallyZero) ? cy : fy_reg;

    assign tally_inc = (tally_reg == TallyFull) ? TallyFull : tally_reg + 1'b1;

    always_comb
    begin
        ctl.lane0_en = (tally_reg != TallyZero);
        ctl.lane1_en = vtx.last_vertex;
        ctl.fresh    = (tally_reg == TallyZero) || (tally_reg == TallyOne);
        ctl.emit     = vtx.last_vertex;
        ctl.too_few  = (tally_inc != TallyFull);
        ctl.mode     = mode_reg;
    end

    assign job_push = beat && (vtx.op == OpVertex)
                      && ((tally_reg != TallyZero) || vtx.last_vertex);
    assign job_data = {ctl, qx_reg, qy_reg, px_reg, py_reg, cx, cy, fx, fy};

    always_comb
    begin
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        tally_next = tally_reg;
        if (beat)
        begin
            case (vtx.op)
                OpStart:
                begin
                    qx_next    = cx;
                    qy_next    = cy;
                    tally_next = TallyZero;
                end
                OpVertex:
                begin
                    fx_next    = fx;
                    fy_next    = fy;
                    px_next    = cx;
                    py_next    = cy;
                    tally_next = vtx.last_vertex ? TallyZero : tally_inc;
                end
                default:
                begin
                    tally_next = tally_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg    <= '0;
            qy_reg    <= '0;
            tally_reg <= TallyZero;
            mode_reg  <= 1'b1;
        end
        else
        begin
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            tally_reg <= tally_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    // only read once tally shows a vertex was stored
    always_ff @(posedge clk)
    begin
        fx_reg <= fx_next;
        fy_reg <= fy_next;
        px_reg <= px_next;
        py_reg <= py_next;
    end

endmodule

// ----- rtl/core/pipc_edge.sv -----
// pipc_edge: one edge lane, three stages of differences, split partial products
// and product sums for the cross-multiplied crossing test; depends on nothing

module pipc_edge #(
    parameter int COORD_BITS = 32
) (
    input  logic                           clk,
    input  logic                           adv,
    input  logic                           en,
    input  logic signed [COORD_BITS-1:0]   ax,
    input  logic signed [COORD_BITS-1:0]   ay,
    input  logic signed [COORD_BITS-1:0]   bx,
    input  logic signed [COORD_BITS-1:0]   by,
    input  logic signed [COORD_BITS-1:0]   qx,
    input  logic signed [COORD_BITS-1:0]   qy,
    output logic                           hit,
    output logic                           dy_neg,
    output logic signed [2*COORD_BITS+1:0] lhs,
    output logic signed [2*COORD_BITS+1:0] rhs
);
    localparam int D  = COORD_BITS + 1;
    localparam int H  = D / 2;
    localparam int PL = D + H + 1;
    localparam int PH = 2 * D - H;
    localparam int PW = 2 * D;

    logic signed [D-1:0]  dqx_reg, dy_reg, dbx_reg, dqy_reg;
    logic signed [D-1:0]  dqx_next, dy_next, dbx_next, dqy_next;
    logic                 hit1_reg, neg1_reg, hit1_next, neg1_next;
    logic signed [PL-1:0] lpl_reg, rpl_reg, lpl_next, rpl_next;
    logic signed [PH-1:0] lph_reg, rph_reg, lph_next, rph_next;
    logic                 hit2_reg, neg2_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg, lhs_next, rhs_next;
    logic                 hit3_reg, neg3_reg;

    // stage 1: differences and straddle check
    always_comb
    begin
        dqx_next  = $signed({qx[COORD_BITS-1], qx}) - $signed({ax[COORD_BITS-1], ax});
        dy_next   = $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
        dbx_next  = $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
        dqy_next  = $signed({qy[COORD_BITS-1], qy}) - $signed({ay[COORD_BITS-1], ay});
        hit1_next = en && ((ay > qy) != (by > qy));
        neg1_next = (by < ay);
    end

    // stage 2: second factor split into unsigned low and signed high halves
    always_comb
    begin
        lpl_next = dqx_reg * $signed({1'b0, dy_reg[H-1:0]});
        lph_next = dqx_reg * $signed(dy_reg[D-1:H]);
        rpl_next = dbx_reg * $signed({1'b0, dqy_reg[H-1:0]});
        rph_next = dbx_reg * $signed(dqy_reg[D-1:H]);
    end

    // stage 3: recombine partial products
    always_comb
    begin
        lhs_next = $signed({lph_reg, {H{1'b0}}})
                   + $signed({{(PW - PL){lpl_reg[PL-1]}}, lpl_reg});
        rhs_next = $signed({rph_reg, {H{1'b0}}})
                   + $signed({{(PW - PL){rpl_reg[PL-1]}}, rpl_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dqx_reg  <= dqx_next;
            dy_reg   <= dy_next;
            dbx_reg  <= dbx_next;
            dqy_reg  <= dqy_next;
            hit1_reg <= hit1_next;
            neg1_reg <= neg1_next;
            lpl_reg  <= lpl_next;
            lph_reg  <= lph_next;
            rpl_reg  <= rpl_next;
            rph_reg  <= rph_next;
            hit2_reg <= hit1_reg;
            neg2_reg <= neg1_reg;
            lhs_reg  <= lhs_next;
            rhs_reg  <= rhs_next;
            hit3_reg <= hit2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    assign hit    = hit3_reg;
    assign dy_neg = neg3_reg;
    assign lhs    = lhs_reg;
    assign rhs    = rhs_reg;

endmodule

// ----- rtl/core/pipc_back.sv -----
// pipc_back: pops edge jobs, runs edge lanes 0 and 1, folds crossings into parity
// and holds the result register; depends on pipc_pkg, pipc_edge, pipc_out_if

module pipc_back #(
    parameter int COORD_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    input  logic [8*COORD_BITS+5:0] job_data,
    output logic                    job_pop,
    pipc_out_if.source              res
);
    import pipc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB + 2;

    job_ctl_t             head_ctl;
    logic signed [CB-1:0] qx, qy, px, py, cx, cy, fx, fy;
    logic                 adv;
    logic                 v1_reg, v2_reg, v3_reg;
    job_ctl_t             ctl1_reg, ctl2_reg, ctl3_reg;
    logic                 hit0, neg0, hit1, neg1;
    logic signed [PW-1:0] lhs0, rhs0, lhs1, rhs1;
    logic                 t0, t1, par;
    logic                 par_reg, par_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 inside_reg, few_reg;

    assign head_ctl = job_ctl_t'(job_data[8*CB+5:8*CB]);
    assign qx = job_data[8*CB-1:7*CB];
    assign qy = job_data[7*CB-1:6*CB];
    assign px = job_data[6*CB-1:5*CB];
    assign py = job_data[5*CB-1:4*CB];
    assign cx = job_data[4*CB-1:3*CB];
    assign cy = job_data[3*CB-1:2*CB];
    assign fx = job_data[2*CB-1:CB];
    assign fy = job_data[CB-1:0];

    assign adv     = !out_valid_reg || res.ready;
    assign job_pop = adv && job_valid;

    // lane 0 closes previous to current, lane 1 closes current to first
    pipc_edge #(.COORD_BITS(CB)) u_lane0 (
        .clk    (clk),
        .adv    (adv),
        .en     (head_ctl.lane0_en),
        .ax     (px),
        .ay     (py),
        .bx     (cx),
        .by     (cy),
        .qx     (qx),
        .qy     (qy),
        .hit    (hit0),
        .dy_neg (neg0),
        .lhs    (lhs0),
        .rhs    (rhs0)
    );

    pipc_edge #(.COORD_BITS(CB)) u_lane1 (
        .clk    (clk),
        .adv    (adv),
        .en     (head_ctl.lane1_en),
        .ax     (cx),
        .ay     (cy),
        .bx     (fx),
        .by     (fy),
        .qx     (qx),
        .qy     (qy),
        .hit    (hit1),
        .dy_neg (neg1),
        .lhs    (lhs1),
        .rhs    (rhs1)
    );

    assign t0  = hit0 && (neg0 ? (lhs0 > rhs0) : (lhs0 < rhs0));
    assign t1  = hit1 && (neg1 ? (lhs1 > rhs1) : (lhs1 < rhs1));
    assign par = (ctl3_reg.fresh ? 1'b0 : par_reg) ^ t0 ^ t1;

    always_comb
    begin
        par_next       = par_reg;
        out_valid_next = out_valid_reg && !res.ready;
        if (adv && v3_reg)
        begin
            par_next       = ctl3_reg.emit ? 1'b0 : par;
            out_valid_next = ctl3_reg.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            par_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= job_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
            par_reg       <= par_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl1_reg <= head_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            if (v3_reg && ctl3_reg.emit)
            begin
                inside_reg <= ctl3_reg.mode ? par : 1'b1;
                few_reg    <= ctl3_reg.too_few;
            end
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.inside_res       = inside_reg;
    assign res.too_few_vertices = few_reg;

endmodule

// ----- rtl/core/point_in_polygon_crossing.sv -----
// point_in_polygon_crossing: even-odd ray-crossing point-in-polygon test, top level
// depends on pipc_pkg, pipc_in_if, pipc_out_if, pipc_front, pipc_fifo, pipc_back
//
// usage
//   vtx beat with op start loads the query point and opens a polygon
//   vtx beats with op vertex follow in order; last_vertex closes the polygon
//   one res beat per polygon: inside_res and too_few_vertices
//   cfg_we/cfg_data write the zone test enable (reset 1); 0 forces inside_res high
// throughput
//   one vtx beat per cycle sustained while the job queue has room, start and vertex alike
//   the closing vertex runs both of its edges in parallel, in lanes 0 and 1
// result path
//   the closing vertex beat writes the queue, then its job passes the difference
//   stage, partial product stage and product sum stage into the result register
// reset
//   query point cleared to zero, parity and vertex count cleared, queue empty,
//   zone test enabled; vtx ready right after reset
// stall
//   when res is held off the back pipeline freezes, the job queue fills
//   and vtx ready drops once the queue is full

module point_in_polygon_crossing #(
    parameter int COORD_BITS  = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    pipc_in_if.sink    vtx,
    pipc_out_if.source res,
    input  logic       cfg_we,
    input  logic       cfg_data
);
    import pipc_pkg::*;

    localparam int JobBits = 8 * COORD_BITS + $bits(job_ctl_t);

    logic               job_push, job_room, job_pop, job_valid;
    logic [JobBits-1:0] push_data, pop_data;

    pipc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx      (vtx),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .job_room (job_room),
        .job_push (job_push),
        .job_data (push_data)
    );

    pipc_fifo #(.WIDTH(JobBits), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (push_data),
        .push_ready (job_room),
        .pop        (job_pop),
        .pop_valid  (job_valid),
        .pop_data   (pop_data)
    );

    pipc_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_data  (pop_data),
        .job_pop   (job_pop),
        .res       (res)
    );

    a_push_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (vtx.valid && vtx.ready))
        else $error("job pushed without an input beat");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> job_room)
        else $error("job pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job popped from an empty queue");

endmodule
